@@ design/tto_pkg.sv @@
`timescale 1ns / 1ps

package tto_pkg;

    // Glyph geometry: 5x7 font drawn at 2x scale on a 12 pixel pitch.
    localparam int CELL_PITCH = 12;
    localparam int GLYPH_W    = 10;
    localparam int GLYPH_H    = 14;
    localparam int PAD_X      = 5;
    localparam int PAD_Y      = 3;
    localparam int GLYPH_SPACE = 12;

    // Configuration register indexes.
    localparam int          CFG_IDX_W        = 3;
    localparam logic [2:0]  REG_BADGE_X      = 3'd0;
    localparam logic [2:0]  REG_BADGE_Y      = 3'd1;
    localparam logic [2:0]  REG_TEXT_CHARS   = 3'd2;
    localparam logic [2:0]  REG_TEXT_LENGTH  = 3'd3;
    localparam logic [2:0]  REG_IMAGE_WIDTH  = 3'd4;
    localparam logic [2:0]  REG_IMAGE_HEIGHT = 3'd5;

    localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;
    localparam logic [7:0]  WHITE            = 8'hFF;

    // Rows of each glyph, MSB is the leftmost dot. Digits, colon, period, space.
    localparam logic [4:0] FONT_ROWS [0:12][0:6] = '{
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
        '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
        '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
        '{5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00}
    };

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Stage 1 result: box and glyph-area decisions plus the cell offsets.
    typedef struct packed {
        logic       box;
        logic       glyph;
        logic [6:0] dx;
        logic [2:0] row;
        t_rgb       rgb;
    } t_s1;

    // Stage 2 result: which glyph, which dot.
    typedef struct packed {
        logic       box;
        logic       glyph_ok;
        logic [3:0] gidx;
        logic [2:0] row;
        logic [2:0] col;
        t_rgb       rgb;
    } t_s2;

    function automatic logic [3:0] glyph_of(input logic [7:0] code);
        logic [3:0] g;
        if (code >= 8'h30 && code <= 8'h39) begin
            g = 4'(code - 8'h30);
        end else if (code == 8'h3A) begin
            g = 4'd10;
        end else if (code == 8'h2E) begin
            g = 4'd11;
        end else begin
            g = 4'(GLYPH_SPACE);
        end
        return g;
    endfunction

    function automatic logic [4:0] font_row(input logic [3:0] gidx, input logic [2:0] row);
        logic [4:0] bits;
        if (gidx <= 4'(GLYPH_SPACE) && row <= 3'd6) begin
            bits = FONT_ROWS[gidx][row];
        end else begin
            bits = 5'd0;
        end
        return bits;
    endfunction

    // (v * 3) / 16 without a multiplier.
    function automatic logic [7:0] dim(input logic [7:0] v);
        logic [9:0] s;
        s = {2'b00, v} + {1'b0, v, 1'b0};
        return 8'(s >> 4);
    endfunction

endpackage

@@ design/tto_pix_if.sv @@
`timescale 1ns / 1ps

interface tto_pix_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;

    modport source (output valid, pixel_x, pixel_y, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, pixel_x, pixel_y, in_red, in_green, in_blue, output ready);
endinterface

@@ design/tto_rgb_if.sv @@
`timescale 1ns / 1ps

interface tto_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;

    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

@@ design/tto_geom.sv @@
`timescale 1ns / 1ps

module tto_geom (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [11:0]        i_px,
    input  logic [11:0]        i_py,
    input  tto_pkg::t_rgb      i_rgb,
    input  logic signed [12:0] i_badge_x,
    input  logic signed [12:0] i_badge_y,
    input  logic [3:0]         i_len,
    input  logic [12:0]        i_width,
    input  logic [12:0]        i_height,
    output logic               o_valid,
    input  logic               i_ready,
    output tto_pkg::t_s1       o_s1
);
    import tto_pkg::*;

    localparam logic signed [14:0] X_LO = -15'(PAD_X);
    localparam logic signed [14:0] Y_LO = -15'(PAD_Y);
    localparam logic signed [14:0] Y_HI = 15'(GLYPH_H + PAD_Y);

    logic               r_valid;
    t_s1                r_s1;
    t_s1                n_s1;
    logic signed [14:0] dx;
    logic signed [14:0] dy;
    logic signed [14:0] span;
    logic [6:0]         pitch;
    logic               en;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_s1    = r_s1;

    always_comb begin
        pitch = 7'(i_len) * 7'(CELL_PITCH);
        span  = $signed({8'b0, pitch});
        dx    = $signed({3'b000, i_px}) - 15'(i_badge_x);
        dy    = $signed({3'b000, i_py}) - 15'(i_badge_y);
        en    = (i_len != 4'd0) && (i_width != 13'd0) && (i_height != 13'd0)
                && ({1'b0, i_px} < i_width) && ({1'b0, i_py} < i_height);

        n_s1.box   = en && (dx >= X_LO) && (dx <= span + 15'(PAD_X))
                     && (dy >= Y_LO) && (dy <= Y_HI);
        n_s1.glyph = en && !dx[14] && (dx < span) && !dy[14] && (dy < 15'(GLYPH_H));
        n_s1.dx    = dx[6:0];
        n_s1.row   = dy[3:1];
        n_s1.rgb   = i_rgb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1 <= n_s1;
        end
    end

endmodule

@@ design/tto_cell.sv @@
`timescale 1ns / 1ps

module tto_cell #(
    parameter int MAX_CHARS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  tto_pkg::t_s1           i_s1,
    input  logic [MAX_CHARS*8-1:0] i_chars,
    output logic                   o_valid,
    input  logic                   i_ready,
    output tto_pkg::t_s2           o_s2
);
    import tto_pkg::*;

    logic       r_valid;
    t_s2        r_s2;
    t_s2        n_s2;
    logic [8:0] prod;
    logic [2:0] ci;
    logic [6:0] off;
    logic [7:0] code;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_s2    = r_s2;

    always_comb begin
        // dx / 12 for dx below 96: (dx / 4) * 11 / 32 is exact in that range.
        prod = 9'(i_s1.dx[6:2]) * 9'd11;
        ci   = prod[7:5];
        off  = i_s1.dx - 7'(ci) * 7'(CELL_PITCH);
        code = 8'd0;
        for (int k = 0; k < MAX_CHARS; k++) begin
            if (ci == 3'(k)) begin
                code = i_chars[k*8 +: 8];
            end
        end
        n_s2.box      = i_s1.box;
        n_s2.glyph_ok = i_s1.glyph && (off < 7'(GLYPH_W));
        n_s2.gidx     = glyph_of(code);
        n_s2.row      = i_s1.row;
        n_s2.col      = off[3:1];
        n_s2.rgb      = i_s1.rgb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s2 <= n_s2;
        end
    end

endmodule

@@ design/tto_shade.sv @@
`timescale 1ns / 1ps

module tto_shade (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tto_pkg::t_s2  i_s2,
    output logic          o_valid,
    input  logic          i_ready,
    output tto_pkg::t_rgb o_rgb
);
    import tto_pkg::*;

    logic       r_valid;
    t_rgb       r_rgb;
    t_rgb       n_rgb;
    logic [7:0] dots;
    logic       lit;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rgb   = r_rgb;

    always_comb begin
        dots = {3'b000, font_row(i_s2.gidx, i_s2.row)};
        lit  = i_s2.glyph_ok && dots[3'd4 - i_s2.col];
        if (lit) begin
            n_rgb = '{red: WHITE, green: WHITE, blue: WHITE};
        end else if (i_s2.box) begin
            n_rgb.red   = dim(i_s2.rgb.red);
            n_rgb.green = dim(i_s2.rgb.green);
            n_rgb.blue  = dim(i_s2.rgb.blue);
        end else begin
            n_rgb = i_s2.rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rgb <= n_rgb;
        end
    end

endmodule

@@ design/timecode_text_overlay.sv @@
`timescale 1ns / 1ps

// Text badge overlay for a pixel stream. Each request carries one pixel with
// its position; the block returns the same pixel dimmed to 3/16 when it lies
// in the padded box around the text, white when it lands on a lit dot of the
// 2x scaled 5x7 font (digits, colon, period, anything else blank), and
// untouched otherwise. It takes one pixel on every clock unless a stalled
// output has backed up to the input. It has three register stages (position
// compare, character cell decode, font lookup and shading). Each stage holds
// its own valid bit and moves forward whenever the stage after it is empty
// or being drained, so bubbles close up and a stalled output only holds back
// the pixels behind it. The user must write registers through the plain write
// port only while no pixels are in flight; the block does not enforce it.

module timecode_text_overlay #(
    parameter int MAX_CHARS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tto_pix_if.sink                    i_pix,
    tto_rgb_if.source                  o_rgb,
    input  logic                       i_cfg_we,
    input  logic [tto_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]                i_cfg_data
);
    import tto_pkg::*;

    // Configuration registers.
    logic signed [12:0]     r_badge_x;
    logic signed [12:0]     r_badge_y;
    logic [MAX_CHARS*8-1:0] r_text_chars;
    logic [3:0]             r_text_length;
    logic [12:0]            r_image_width;
    logic [12:0]            r_image_height;

    logic [3:0] eff_len;
    t_rgb       in_rgb;
    t_rgb       out_rgb;
    t_s1        s1;
    t_s2        s2;
    logic       s1_valid;
    logic       s1_ready;
    logic       s2_valid;
    logic       s2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_badge_x      <= '0;
            r_badge_y      <= '0;
            r_text_chars   <= '0;
            r_text_length  <= '0;
            r_image_width  <= IMAGE_WIDTH_RST;
            r_image_height <= IMAGE_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BADGE_X:      r_badge_x      <= $signed(i_cfg_data[12:0]);
                REG_BADGE_Y:      r_badge_y      <= $signed(i_cfg_data[12:0]);
                REG_TEXT_CHARS:   r_text_chars   <= i_cfg_data[MAX_CHARS*8-1:0];
                REG_TEXT_LENGTH:  r_text_length  <= i_cfg_data[3:0];
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[12:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    // A length beyond the text buffer draws the whole buffer.
    assign eff_len = (r_text_length > 4'(MAX_CHARS)) ? 4'(MAX_CHARS) : r_text_length;

    assign in_rgb = '{red: i_pix.in_red, green: i_pix.in_green, blue: i_pix.in_blue};

    tto_geom u_geom (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_pix.valid),
        .o_ready   (i_pix.ready),
        .i_px      (i_pix.pixel_x),
        .i_py      (i_pix.pixel_y),
        .i_rgb     (in_rgb),
        .i_badge_x (r_badge_x),
        .i_badge_y (r_badge_y),
        .i_len     (eff_len),
        .i_width   (r_image_width),
        .i_height  (r_image_height),
        .o_valid   (s1_valid),
        .i_ready   (s1_ready),
        .o_s1      (s1)
    );

    tto_cell #(
        .MAX_CHARS (MAX_CHARS)
    ) u_cell (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_s1    (s1),
        .i_chars (r_text_chars),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_s2    (s2)
    );

    tto_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_s2    (s2),
        .o_valid (o_rgb.valid),
        .i_ready (o_rgb.ready),
        .o_rgb   (out_rgb)
    );

    assign o_rgb.out_red   = out_rgb.red;
    assign o_rgb.out_green = out_rgb.green;
    assign o_rgb.out_blue  = out_rgb.blue;

endmodule

@@ design/tto_checker.sv @@
`timescale 1ns / 1ps

module tto_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_red,
    input logic [7:0] i_out_green,
    input logic [7:0] i_out_blue
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // With the output stage empty, every stage can move, so input is open.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked while output stage is empty");

    // A request passes the geometry, cell and shade registers to reach the output
    // stage unless something is already waiting there.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |-> ##3 i_out_valid)
        else $error("accepted pixel did not reach the output in time");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_red)
            && $stable(i_out_green) && $stable(i_out_blue)))
        else $error("stalled output changed");

endmodule

bind timecode_text_overlay tto_checker u_tto_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_out_red   (o_rgb.out_red),
    .i_out_green (o_rgb.out_green),
    .i_out_blue  (o_rgb.out_blue)
);

@@ tb/overlay_checker.sv @@
`timescale 1ns / 1ps

module overlay_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tto_pix_if                            i_pix,
    tto_rgb_if                            i_rgb,
    input  logic                          i_cfg_we,
    input  logic [tto_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]                   i_cfg_data,
    output int                            o_outstanding,
    output int                            o_mismatches
);
    import tto_pkg::*;

    localparam int MAX_TEXT = 8;

    // Font slots of the characters that have a glyph.
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [3:0] SLOT_COLON  = 4'd10;
    localparam logic [3:0] SLOT_PERIOD = 4'd11;
    localparam logic [3:0] SLOT_BLANK  = 4'd12;

    // Dot rows of each glyph; bit 4 is the leftmost dot.
    localparam logic [4:0] GLYPH_DOTS [13][7] = '{
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
        '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
        '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
        '{5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00}
    };

    // Shadow copy of the overlay settings.
    logic signed [12:0] org_x;
    logic signed [12:0] org_y;
    logic [63:0]        label;
    logic [3:0]         label_len;
    logic [12:0]        img_w;
    logic [12:0]        img_h;

    t_rgb shaded_q[$];
    t_rgb want;
    int   mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic logic [3:0] font_slot(input logic [7:0] ch);
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            return 4'(ch - CH_ZERO);
        end
        if (ch == CH_COLON) begin
            return SLOT_COLON;
        end
        if (ch == CH_PERIOD) begin
            return SLOT_PERIOD;
        end
        return SLOT_BLANK;
    endfunction

    function automatic logic [7:0] dim_3_16(input logic [7:0] v);
        int t;
        t = (int'(v) * 3) / 16;
        return 8'(t);
    endfunction

    function automatic t_rgb shade_pixel(input logic [11:0] px_in, input logic [11:0] py_in,
                                         input t_rgb c);
        longint px, py, len, w, h, x, y, x1, y1, x2, y2, dx, dy;
        int         char_idx, off;
        logic [4:0] dots;
        t_rgb       o;
        o   = c;
        px  = longint'(px_in);
        py  = longint'(py_in);
        len = (label_len > 4'(MAX_TEXT)) ? longint'(MAX_TEXT) : longint'(label_len);
        w   = longint'(img_w);
        h   = longint'(img_h);
        if (len > 0 && w > 0 && h > 0 && px < w && py < h) begin
            x  = longint'(org_x);
            y  = longint'(org_y);
            x1 = (x - 5 < 0) ? 0 : x - 5;
            y1 = (y - 3 < 0) ? 0 : y - 3;
            x2 = x + len * 12 + 5;
            y2 = y + 17;
            if (x2 > w - 1) begin
                x2 = w - 1;
            end
            if (y2 > h - 1) begin
                y2 = h - 1;
            end
            dx = px - x;
            dy = py - y;
            if (px >= x1 && px <= x2 && py >= y1 && py <= y2) begin
                o.red   = dim_3_16(o.red);
                o.green = dim_3_16(o.green);
                o.blue  = dim_3_16(o.blue);
            end
            if (dx >= 0 && dx < len * 12 && dy >= 0 && dy < 14) begin
                char_idx = int'(dx / 12);
                off      = int'(dx % 12);
                if (off < 10) begin
                    dots = GLYPH_DOTS[font_slot(label[char_idx*8 +: 8])][int'(dy / 2)];
                    if (dots[4 - off / 2]) begin
                        o = '{8'hFF, 8'hFF, 8'hFF};
                    end
                end
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        $display("MISMATCH %s: expected %02h, got %02h at %0t ns", what, exp_val, got_val,
                 $realtime);
        mismatch_count++;
    endtask

    // Results are compared before the new request is predicted, and the settings are
    // updated last, so each step sees the values that stood before the edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            org_x     <= '0;
            org_y     <= '0;
            label     <= '0;
            label_len <= '0;
            img_w     <= 13'd640;
            img_h     <= 13'd480;
            shaded_q.delete();
        end else begin
            if (i_rgb.valid && i_rgb.ready) begin
                if (shaded_q.size() == 0) begin
                    report_mismatch("unexpected result", 0, int'(i_rgb.out_red));
                end else begin
                    want = shaded_q.pop_front();
                    if (i_rgb.out_red !== want.red) begin
                        report_mismatch("out_red", int'(want.red), int'(i_rgb.out_red));
                    end
                    if (i_rgb.out_green !== want.green) begin
                        report_mismatch("out_green", int'(want.green),
                                        int'(i_rgb.out_green));
                    end
                    if (i_rgb.out_blue !== want.blue) begin
                        report_mismatch("out_blue", int'(want.blue), int'(i_rgb.out_blue));
                    end
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                shaded_q.push_back(shade_pixel(i_pix.pixel_x, i_pix.pixel_y,
                    '{i_pix.in_red, i_pix.in_green, i_pix.in_blue}));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BADGE_X:      org_x     <= i_cfg_data[12:0];
                    REG_BADGE_Y:      org_y     <= i_cfg_data[12:0];
                    REG_TEXT_CHARS:   label     <= i_cfg_data;
                    REG_TEXT_LENGTH:  label_len <= i_cfg_data[3:0];
                    REG_IMAGE_WIDTH:  img_w     <= i_cfg_data[12:0];
                    REG_IMAGE_HEIGHT: img_h     <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
        end
        o_outstanding <= shaded_q.size();
    end

endmodule

@@ tb/tb_timecode_text_overlay.sv @@
`timescale 1ns / 1ps

// Top of the overlay bench. It only makes stimulus: it programs the badge
// settings while the block is idle, streams pixel requests, and wiggles the
// result-side ready. The checker beside the block predicts every pixel and
// counts mismatches; this module turns that count into the verdict.
module tb_timecode_text_overlay;
    import tto_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 11;
    localparam int PHASE_PIXELS   = 48;
    // The glyph set, used to bias random text toward characters that draw dots.
    localparam string FONT_CHARS  = "0123456789:.";

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [63:0]          cfg_data = '0;

    int outstanding;
    int mismatches;
    int quiet_cycles = 0;
    bit bubbles_on   = 1'b1;

    // Current settings, kept here only to aim random pixels at the badge.
    int cur_x, cur_y, cur_len;

    tto_pix_if pix ();
    tto_rgb_if rgb ();

    timecode_text_overlay #(.MAX_CHARS(8)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix),
        .o_rgb      (rgb),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    overlay_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix         (pix),
        .i_rgb         (rgb),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_outstanding (outstanding),
        .o_mismatches  (mismatches)
    );

    always #2 i_clk = ~i_clk;

    // The watchdog restarts on any accepted request, result or register write,
    // so a hung pipeline ends the run instead of hanging the simulator.
    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (rgb.valid && rgb.ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Result-side back-pressure: random stall bursts between runs of ready. Each
    // pass may drop ready for a burst, then raises it and moves to a later edge.
    always begin
        @(posedge i_clk);
        if (bubbles_on && $urandom_range(0, 3) == 0) begin
            rgb.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        rgb.ready <= 1'b1;
        repeat ($urandom_range(0, 11)) @(posedge i_clk);
    end

    // Packs a string so that its first character lands in the lowest byte.
    function automatic logic [63:0] pack_text(input string s);
        logic [63:0] t;
        t = '0;
        for (int i = 0; i < s.len() && i < 8; i++) begin
            t[i*8 +: 8] = s[i];
        end
        return t;
    endfunction

    // Three bytes in four come from the glyph set; the rest are any byte,
    // which covers the characters that must draw as blanks.
    function automatic logic [63:0] random_text();
        logic [63:0] t;
        for (int i = 0; i < 8; i++) begin
            if ($urandom_range(0, 3) != 0) begin
                t[i*8 +: 8] = FONT_CHARS[$urandom_range(0, 11)];
            end else begin
                t[i*8 +: 8] = 8'($urandom_range(0, 255));
            end
        end
        return t;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Writes the whole register set back to back; the enable stays high across
    // the writes and drops once after the last one.
    task automatic program_overlay(input int x, input int y, input logic [63:0] text,
                                   input int len, input int w, input int h);
        cur_x   = x;
        cur_y   = y;
        cur_len = len;
        write_reg(REG_BADGE_X, {51'd0, 13'(x)});
        write_reg(REG_BADGE_Y, {51'd0, 13'(y)});
        write_reg(REG_TEXT_CHARS, text);
        write_reg(REG_TEXT_LENGTH, {60'd0, 4'(len)});
        write_reg(REG_IMAGE_WIDTH, {51'd0, 13'(w)});
        write_reg(REG_IMAGE_HEIGHT, {51'd0, 13'(h)});
        cfg_we <= 1'b0;
    endtask

    // Presents one pixel request and returns at the edge where it is taken.
    // An optional source gap comes first; valid stays high between requests
    // that follow each other without a gap.
    task automatic send_pixel(input int x, input int y, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b);
        if (bubbles_on && $urandom_range(0, 3) == 0) begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        pix.valid    <= 1'b1;
        pix.pixel_x  <= 12'(x);
        pix.pixel_y  <= 12'(y);
        pix.in_red   <= r;
        pix.in_green <= g;
        pix.in_blue  <= b;
        do @(posedge i_clk); while (!pix.ready);
    endtask

    // Drains the pipeline before the settings change. Every request makes a
    // result, so once nothing is owed the three stages are empty as well.
    task automatic drain();
        pix.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] random_level();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Most pixels land in or just around the badge so that the box edges,
    // gaps between cells and glyph dots are all hit; a quarter of them go
    // anywhere in the coordinate range.
    task automatic send_random_pixel();
        int span, x, y;
        span = 12 * ((cur_len == 0) ? 1 : ((cur_len > 8) ? 8 : cur_len)) + 16;
        if ($urandom_range(0, 3) != 0) begin
            x = cur_x - 8 + int'($urandom_range(0, span));
            y = cur_y - 5 + int'($urandom_range(0, 25));
        end else begin
            x = int'($urandom_range(0, 4095));
            y = int'($urandom_range(0, 4095));
        end
        if (x < 0 || x > 4095) begin
            x = int'($urandom_range(0, 4095));
        end
        if (y < 0 || y > 4095) begin
            y = int'($urandom_range(0, 4095));
        end
        send_pixel(x, y, random_level(), random_level(), random_level());
    endtask

    // Random settings: mostly a badge placed in a normal frame, sometimes any
    // 13-bit origin, zero length, a length above eight, or an empty, tiny or
    // oversized image.
    task automatic random_settings();
        int x, y, len, w, h;
        x = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 8191)) - 4096
                                        : int'($urandom_range(0, 720)) - 20;
        y = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 8191)) - 4096
                                        : int'($urandom_range(0, 500)) - 20;
        case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = int'($urandom_range(9, 15));
            default: len = int'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 9))
            0:       w = 0;
            1:       w = int'($urandom_range(1, 40));
            2:       w = int'($urandom_range(0, 8191));
            default: w = int'($urandom_range(100, 1920));
        endcase
        case ($urandom_range(0, 9))
            0:       h = 0;
            1:       h = int'($urandom_range(1, 30));
            2:       h = int'($urandom_range(0, 8191));
            default: h = int'($urandom_range(100, 1080));
        endcase
        program_overlay(x, y, random_text(), len, w, h);
    endtask

    initial begin
        logic [63:0] text;

        pix.valid    <= 1'b0;
        pix.pixel_x  <= '0;
        pix.pixel_y  <= '0;
        pix.in_red   <= '0;
        pix.in_green <= '0;
        pix.in_blue  <= '0;
        rgb.ready    <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With the reset settings the text is empty, so pixels pass unchanged.
        send_pixel(0, 0, 8'h00, 8'h00, 8'h00);
        send_pixel(4095, 4095, 8'hFF, 8'hFF, 8'hFF);
        drain();

        // Eight cells: digits, colon, period, a byte above 0x7F and a space.
        text = pack_text("10:.9?8 ");
        text[47:40] = 8'hFF;
        program_overlay(20, 10, text, 8, 640, 480);
        send_pixel(24, 10, 8'h12, 8'h34, 8'h56);   // lit dot of the first digit
        send_pixel(20, 10, 8'hFF, 8'hFF, 8'hFF);   // dark dot, dimmed only
        send_pixel(30, 10, 8'hFF, 8'h80, 8'h01);   // gap between two cells
        send_pixel(46, 12, 8'h00, 8'h00, 8'h00);   // colon
        send_pixel(58, 20, 8'h40, 8'h40, 8'h40);   // period
        send_pixel(84, 16, 8'hAB, 8'hCD, 8'hEF);   // byte drawn as a blank
        send_pixel(15, 7, 8'hFF, 8'hFF, 8'hFF);    // top-left corner of the box
        send_pixel(14, 7, 8'hFF, 8'hFF, 8'hFF);    // just left of the box
        send_pixel(121, 27, 8'hFF, 8'hFF, 8'hFF);  // bottom-right corner
        send_pixel(122, 27, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(121, 28, 8'hFF, 8'hFF, 8'hFF);
        drain();

        // A length above eight draws eight cells.
        program_overlay(0, 0, text, 15, 640, 480);
        send_pixel(74, 0, 8'h10, 8'h20, 8'h30);
        send_pixel(101, 5, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(102, 5, 8'hFF, 8'hFF, 8'hFF);
        drain();

        // Box clipped by a small image, and pixels beyond the image edge.
        program_overlay(20, 10, text, 8, 30, 20);
        send_pixel(24, 10, 8'h11, 8'h22, 8'h33);
        send_pixel(35, 10, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(25, 19, 8'hFF, 8'hFF, 8'hFF);
        drain();

        // An empty image disables the overlay.
        program_overlay(20, 10, text, 8, 0, 480);
        send_pixel(24, 10, 8'h11, 8'h22, 8'h33);
        drain();

        // Origin left of and above the image: the box clamps at zero.
        program_overlay(-6, -3, text, 8, 640, 480);
        send_pixel(0, 0, 8'hFF, 8'h7F, 8'h80);
        drain();

        // Register extremes: most negative origin with the widest image
        // setting, then the largest origin with a full-size frame.
        program_overlay(-4096, -4096, ~64'd0, 9, 8191, 4096);
        send_pixel(100, 100, 8'hFF, 8'hFF, 8'hFF);
        drain();
        program_overlay(4095, 4095, pack_text("8"), 1, 4096, 4096);
        send_pixel(4095, 4095, 8'hFF, 8'h00, 8'hFF);
        drain();

        // Random phases; the last one runs without any idling on either side.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            bubbles_on = (phase != RANDOM_PHASES - 1);
            random_settings();
            repeat (PHASE_PIXELS) send_random_pixel();
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
